@@ hdl/mqm_pkg.sv @@
// Shared types, constants and helpers for the four-motor X-frame mixer.
// No dependencies; used by every module in the hdl folder.
package mqm_pkg;

	// Fixed-point and field widths
	localparam int FRAC_BITS = 4;
	localparam int DEM_W     = 16;   // demand fields
	localparam int MIX_W     = 16;   // saturated motor mix
	localparam int SUM_W     = DEM_W + 2; // sum of four demands
	localparam int MAG_W     = MIX_W; // magnitude of a mix, up to 32768
	localparam int RPM_W     = 15;
	localparam int QUO_W     = RPM_W; // scaled magnitude never exceeds max_rpm
	localparam int REM_W     = MAG_W + QUO_W - 1; // product below largest << QUO_W
	localparam int LANES     = 4;
	localparam int CELLS     = QUO_W; // one quotient bit per cell

	localparam logic [RPM_W-1:0] RPM_RESET = RPM_W'(2000);

	// Lane order: front_right, back_left, front_left, back_right
	localparam int LANE_FR = 0;
	localparam int LANE_BL = 1;
	localparam int LANE_FL = 2;
	localparam int LANE_BR = 3;

	typedef logic [MIX_W-1:0] mix_t;
	typedef mix_t [LANES-1:0] mix_arr_t;
	typedef logic [MAG_W-1:0] mag_t;

	// One lane of the divider chain
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic             neg;
		mix_t             mix;
	} div_lane_t;

	// Word handed from cell to cell
	typedef struct packed {
		logic                    valid;
		logic                    scaled;
		logic [REM_W-1:0]        dsh;   // divisor aligned to the current quotient bit
		div_lane_t [LANES-1:0]   lane;
	} div_word_t;

	// Truncate toward zero by the fraction bits, then saturate to a 16-bit mix
	function automatic mix_t trunc_sat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] b;
		logic signed [SUM_W-1:0] q;
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		mix_t                    r;
		hi = SUM_W'((1 << (MIX_W - 1)) - 1);
		lo = -SUM_W'(1 << (MIX_W - 1));
		b  = s[SUM_W-1] ? s + SUM_W'((1 << FRAC_BITS) - 1) : s;
		q  = b >>> FRAC_BITS;
		if (q > hi) begin
			r = hi[MIX_W-1:0];
		end else if (q < lo) begin
			r = lo[MIX_W-1:0];
		end else begin
			r = q[MIX_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/mqm_mix.sv @@
// First pipeline stage: forms the four X-frame mixes, truncated and saturated.
// Depends on mqm_pkg.
module mqm_mix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic signed [mqm_pkg::DEM_W-1:0] pitch_demand,
	input  logic signed [mqm_pkg::DEM_W-1:0] roll_demand,
	input  logic signed [mqm_pkg::DEM_W-1:0] yaw_demand,
	input  logic signed [mqm_pkg::DEM_W-1:0] thrust_demand,
	output logic                         valid_s1,
	output mqm_pkg::mix_arr_t            mix_s1
);

	logic signed [mqm_pkg::SUM_W-1:0] p;
	logic signed [mqm_pkg::SUM_W-1:0] r;
	logic signed [mqm_pkg::SUM_W-1:0] y;
	logic signed [mqm_pkg::SUM_W-1:0] t;
	mqm_pkg::mix_arr_t                mix_d;

	// Full-precision sums, one per motor
	always_comb begin
		p = mqm_pkg::SUM_W'(pitch_demand);
		r = mqm_pkg::SUM_W'(roll_demand);
		y = mqm_pkg::SUM_W'(yaw_demand);
		t = mqm_pkg::SUM_W'(thrust_demand);
		mix_d[mqm_pkg::LANE_FR] = mqm_pkg::trunc_sat(t - p + r - y);
		mix_d[mqm_pkg::LANE_BL] = mqm_pkg::trunc_sat(t + p - r - y);
		mix_d[mqm_pkg::LANE_FL] = mqm_pkg::trunc_sat(t - p - r + y);
		mix_d[mqm_pkg::LANE_BR] = mqm_pkg::trunc_sat(t + p + r + y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		mix_s1 <= mix_d;
	end

endmodule

@@ hdl/mqm_prep.sv @@
// Stages two and three: largest magnitude, scale decision, products for the divider.
// Depends on mqm_pkg.
module mqm_prep (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  mqm_pkg::mix_arr_t          mix_s1,
	input  logic [mqm_pkg::RPM_W-1:0]  max_rpm,
	output mqm_pkg::div_word_t         word_s3
);

	mqm_pkg::mag_t [mqm_pkg::LANES-1:0] mag_d;
	mqm_pkg::mag_t                       max01;
	mqm_pkg::mag_t                       max23;
	mqm_pkg::mag_t                       largest_d;

	logic                                valid_s2;
	mqm_pkg::mix_arr_t                   mix_s2;
	mqm_pkg::mag_t [mqm_pkg::LANES-1:0]  mag_s2;
	mqm_pkg::mag_t                       largest_s2;

	logic                                valid_s3;
	mqm_pkg::div_word_t                  data_s3;
	logic [mqm_pkg::MAG_W+mqm_pkg::RPM_W-1:0] prod [mqm_pkg::LANES];

	// Magnitudes and a two-level max tree
	always_comb begin
		for (int i = 0; i < mqm_pkg::LANES; i++) begin
			mag_d[i] = mix_s1[i][mqm_pkg::MIX_W-1] ? mqm_pkg::MAG_W'(-mix_s1[i]) : mix_s1[i];
		end
		max01     = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
		max23     = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
		largest_d = (max01 > max23) ? max01 : max23;
	end

	// Products and the word that enters the divider chain
	always_comb begin
		data_s3 = '0;
		data_s3.scaled = largest_s2 > mqm_pkg::MAG_W'(max_rpm);
		data_s3.dsh    = mqm_pkg::REM_W'(largest_s2) << (mqm_pkg::QUO_W - 1);
		for (int i = 0; i < mqm_pkg::LANES; i++) begin
			prod[i] = (mqm_pkg::MAG_W+mqm_pkg::RPM_W)'(mag_s2[i])
			        * (mqm_pkg::MAG_W+mqm_pkg::RPM_W)'(max_rpm);
			data_s3.lane[i].rem = prod[i][mqm_pkg::REM_W-1:0];
			data_s3.lane[i].quo = '0;
			data_s3.lane[i].neg = mix_s2[i][mqm_pkg::MIX_W-1];
			data_s3.lane[i].mix = mix_s2[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mix_s2     <= mix_s1;
		mag_s2     <= mag_d;
		largest_s2 <= largest_d;
	end

	mqm_pkg::div_word_t pay_s3;

	always_ff @(posedge clk) begin
		pay_s3 <= data_s3;
	end

	always_comb begin
		word_s3       = pay_s3;
		word_s3.valid = valid_s3;
	end

endmodule

@@ hdl/mqm_div_cell.sv @@
// One cell of the divider chain: settles one quotient bit for all four lanes.
// Depends on mqm_pkg.
module mqm_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mqm_pkg::div_word_t word_in,
	output mqm_pkg::div_word_t word_out
);

	mqm_pkg::div_word_t next_d;
	mqm_pkg::div_word_t pay_s1;
	logic               valid_s1;
	logic               ge;

	// Trial subtract of the aligned divisor, then move it one bit down
	always_comb begin
		next_d     = word_in;
		next_d.dsh = word_in.dsh >> 1;
		ge         = 1'b0;
		for (int i = 0; i < mqm_pkg::LANES; i++) begin
			ge = word_in.lane[i].rem >= word_in.dsh;
			next_d.lane[i].rem = ge ? word_in.lane[i].rem - word_in.dsh : word_in.lane[i].rem;
			next_d.lane[i].quo = {word_in.lane[i].quo[mqm_pkg::QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		pay_s1 <= next_d;
	end

	always_comb begin
		word_out       = pay_s1;
		word_out.valid = valid_s1;
	end

endmodule

@@ hdl/quad_x_motor_mixer.sv @@
// X-frame four-motor mixer with proportional scaling to max_rpm.
// Pipeline: mix stage, two prep stages, 15 divider cells and an output register; done and
// the result come out of the output register together.
// Throughput: one item per cycle; busy stays low. The receiver cannot stall.
// Reset clears all valid bits and returns max_rpm to 2000.
// Depends on mqm_pkg, mqm_mix, mqm_prep and mqm_div_cell.
module quad_x_motor_mixer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [mqm_pkg::DEM_W-1:0] pitch_demand,
	input  logic signed [mqm_pkg::DEM_W-1:0] roll_demand,
	input  logic signed [mqm_pkg::DEM_W-1:0] yaw_demand,
	input  logic signed [mqm_pkg::DEM_W-1:0] thrust_demand,
	input  logic                             max_rpm_we,
	input  logic [mqm_pkg::RPM_W-1:0]        max_rpm_wdata,
	output logic                             done,
	output logic signed [mqm_pkg::MIX_W-1:0] front_right,
	output logic signed [mqm_pkg::MIX_W-1:0] back_left,
	output logic signed [mqm_pkg::MIX_W-1:0] front_left,
	output logic signed [mqm_pkg::MIX_W-1:0] back_right,
	output logic                             was_scaled
);

	logic [mqm_pkg::RPM_W-1:0] max_rpm_q;
	logic                      take;
	logic                      valid_s1;
	mqm_pkg::mix_arr_t         mix_s1;
	mqm_pkg::div_word_t        chain [mqm_pkg::CELLS+1];
	mqm_pkg::div_word_t        tail;
	mqm_pkg::mix_arr_t         res_d;
	mqm_pkg::mix_arr_t         res_q;
	logic                      done_q;
	logic                      scaled_q;

	// Fully pipelined, so a transfer is taken every cycle
	assign busy = 1'b0;
	assign take = start && !busy;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rpm_q <= mqm_pkg::RPM_RESET;
		end else if (max_rpm_we) begin
			max_rpm_q <= max_rpm_wdata;
		end
	end

	mqm_mix u_mix (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.pitch_demand  (pitch_demand),
		.roll_demand   (roll_demand),
		.yaw_demand    (yaw_demand),
		.thrust_demand (thrust_demand),
		.valid_s1      (valid_s1),
		.mix_s1        (mix_s1)
	);

	mqm_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.mix_s1   (mix_s1),
		.max_rpm  (max_rpm_q),
		.word_s3  (chain[0])
	);

	// Divider chain, most significant quotient bit first
	for (genvar c = 0; c < mqm_pkg::CELLS; c++) begin : g_cell
		mqm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.word_in  (chain[c]),
			.word_out (chain[c+1])
		);
	end

	assign tail = chain[mqm_pkg::CELLS];

	// Restore the sign, or pass the unscaled mix through
	always_comb begin
		for (int i = 0; i < mqm_pkg::LANES; i++) begin
			if (tail.scaled) begin
				res_d[i] = tail.lane[i].neg ? -mqm_pkg::MIX_W'(tail.lane[i].quo)
				                            :  mqm_pkg::MIX_W'(tail.lane[i].quo);
			end else begin
				res_d[i] = tail.lane[i].mix;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_d;
		scaled_q <= tail.scaled;
	end

	assign done        = done_q;
	assign front_right = res_q[mqm_pkg::LANE_FR];
	assign back_left   = res_q[mqm_pkg::LANE_BL];
	assign front_left  = res_q[mqm_pkg::LANE_FL];
	assign back_right  = res_q[mqm_pkg::LANE_BR];
	assign was_scaled  = scaled_q;

endmodule

@@ test/quad_x_motor_mixer_test.sv @@
// Self-checking testbench for quad_x_motor_mixer: drives demand transfers, predicts
// the four motor mixes and the scaled flag, and checks every result strobe in order.
// Depends on mqm_pkg and the quad_x_motor_mixer RTL.
`timescale 1ns / 100ps

module quad_x_motor_mixer_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 25;   // idle wait after the last result

	typedef logic signed [mqm_pkg::DEM_W-1:0] demand_t;
	typedef logic [mqm_pkg::RPM_W-1:0]        rpm_t;

	// Four motor values in lane order plus the scaled flag
	typedef struct packed {
		logic              scaled;
		mqm_pkg::mix_arr_t mix;
	} motor_set_t;

	logic          clk           = 1'b0;
	logic          arst_n        = 1'b0;
	logic          start         = 1'b0;
	demand_t       pitch_demand  = '0;
	demand_t       roll_demand   = '0;
	demand_t       yaw_demand    = '0;
	demand_t       thrust_demand = '0;
	logic          max_rpm_we    = 1'b0;
	rpm_t          max_rpm_wdata = '0;
	logic          busy;
	logic          done;
	mqm_pkg::mix_t front_right;
	mqm_pkg::mix_t back_left;
	mqm_pkg::mix_t front_left;
	mqm_pkg::mix_t back_right;
	logic          was_scaled;

	motor_set_t pending_mixes [$];
	rpm_t       rpm_limit = mqm_pkg::RPM_RESET;
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         no_idle = 1'b0;
	string      lane_name [mqm_pkg::LANES] =
		'{"front_right", "back_left", "front_left", "back_right"};

	quad_x_motor_mixer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.pitch_demand  (pitch_demand),
		.roll_demand   (roll_demand),
		.yaw_demand    (yaw_demand),
		.thrust_demand (thrust_demand),
		.max_rpm_we    (max_rpm_we),
		.max_rpm_wdata (max_rpm_wdata),
		.done          (done),
		.front_right   (front_right),
		.back_left     (back_left),
		.front_left    (front_left),
		.back_right    (back_right),
		.was_scaled    (was_scaled)
	);

	always #10 clk = ~clk;

	// Mix, truncate toward zero, saturate, then scale down to the limit if exceeded
	function automatic motor_set_t mix_motors(input demand_t p, input demand_t r,
			input demand_t y, input demand_t t, input rpm_t limit);
		longint     sum [mqm_pkg::LANES];
		longint     lane_val [mqm_pkg::LANES];
		longint     peak;
		longint     mag;
		motor_set_t res;
		sum[mqm_pkg::LANE_FR] = longint'(t) - longint'(p) + longint'(r) - longint'(y);
		sum[mqm_pkg::LANE_BL] = longint'(t) + longint'(p) - longint'(r) - longint'(y);
		sum[mqm_pkg::LANE_FL] = longint'(t) - longint'(p) - longint'(r) + longint'(y);
		sum[mqm_pkg::LANE_BR] = longint'(t) + longint'(p) + longint'(r) + longint'(y);
		peak = 0;
		for (int i = 0; i < mqm_pkg::LANES; i++) begin
			lane_val[i] = sum[i] / (longint'(1) << mqm_pkg::FRAC_BITS);
			if (lane_val[i] > 32767)
				lane_val[i] = 32767;
			if (lane_val[i] < -32768)
				lane_val[i] = -32768;
			mag = (lane_val[i] < 0) ? -lane_val[i] : lane_val[i];
			if (mag > peak)
				peak = mag;
		end
		res.scaled = (peak > longint'(limit));
		for (int i = 0; i < mqm_pkg::LANES; i++) begin
			if (res.scaled)
				lane_val[i] = (lane_val[i] * longint'(limit)) / peak;
			res.mix[i] = mqm_pkg::mix_t'(lane_val[i]);
		end
		return res;
	endfunction

	// Mostly full-range values, some small ones and some rail values
	function automatic demand_t pick_demand();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			1, 2: return demand_t'(int'($urandom_range(0, 1023)) - 512);
			default: return demand_t'($urandom);
		endcase
	endfunction

	// Gap before a transfer: usually none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (no_idle || sel < 10)
			return 0;
		if (sel < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One demand transfer; start is left high so back-to-back transfers stay gapless
	task automatic send_demand(input demand_t p, input demand_t r, input demand_t y,
			input demand_t t);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		pitch_demand  <= p;
		roll_demand   <= r;
		yaw_demand    <= y;
		thrust_demand <= t;
		do @(posedge clk); while (busy);
		pending_mixes.push_back(mix_motors(p, r, y, t, rpm_limit));
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_demand(pick_demand(), pick_demand(), pick_demand(), pick_demand());
	endtask

	// Stop sending and wait for every outstanding result
	task automatic finish_phase();
		start <= 1'b0;
		while (pending_mixes.size() != 0)
			@(posedge clk);
	endtask

	// Register write only once the pipeline is empty
	task automatic set_max_rpm(input rpm_t value);
		finish_phase();
		max_rpm_we    <= 1'b1;
		max_rpm_wdata <= value;
		@(posedge clk);
		max_rpm_we <= 1'b0;
		rpm_limit  = value;
	endtask

	// Rails, single-axis demands, truncation and the scaling threshold at reset limit
	task automatic test_directed_mixes();
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_demand(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_demand(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_demand(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_demand(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF);
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sd32000);   // exactly at limit
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sd32016);   // one over limit
		send_demand(16'sd0, 16'sd0, 16'sd0, -16'sd1);      // truncates to zero
		send_demand(16'sd0, 16'sd0, 16'sd0, -16'sd17);
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sd17);
		send_demand(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
		send_demand(16'sd0, 16'sh8000, 16'sd0, 16'sd0);
		send_demand(16'sd0, 16'sd0, 16'sh7FFF, 16'sd0);
		send_demand(16'sd0, 16'sd0, 16'sh8000, -16'sd5);
	endtask

	// Limit at zero, one, the top of the range and around the largest reachable mix
	task automatic test_limit_extremes();
		set_max_rpm(rpm_t'(0));
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sd0);       // zero mixes stay unscaled
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sd16);
		send_random(6);
		set_max_rpm(rpm_t'(1));
		send_demand(16'sd0, 16'sd0, 16'sd0, 16'sd16);
		send_demand(16'sd0, 16'sd0, 16'sd0, -16'sd32);
		send_random(6);
		set_max_rpm(rpm_t'(32767));
		send_demand(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_demand(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_random(6);
		set_max_rpm(rpm_t'(8191));
		send_demand(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_demand(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_random(6);
	endtask

	// Random demands over a spread of limits, one phase without gaps
	task automatic test_random_mixes();
		rpm_t limit;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: limit = mqm_pkg::RPM_RESET;
				1: limit = rpm_t'($urandom_range(1, 32767));
				2: limit = rpm_t'($urandom_range(1, 8192));
				3: limit = rpm_t'($urandom_range(100, 3000));
				4: limit = rpm_t'(32767);
				default: limit = rpm_t'(1);
			endcase
			set_max_rpm(limit);
			no_idle = (phase == 2);
			send_random(70);
		end
		no_idle = 1'b0;
	endtask

	// Compare each result strobe with the oldest prediction
	always @(posedge clk) begin : check_results
		motor_set_t seen;
		motor_set_t want;
		if (arst_n && done) begin
			seen.mix[mqm_pkg::LANE_FR] = front_right;
			seen.mix[mqm_pkg::LANE_BL] = back_left;
			seen.mix[mqm_pkg::LANE_FL] = front_left;
			seen.mix[mqm_pkg::LANE_BR] = back_right;
			seen.scaled                = was_scaled;
			if (pending_mixes.size() == 0) begin
				$display("%0t: unexpected result, nothing outstanding", $time);
				mismatch_count++;
			end else begin
				want = pending_mixes.pop_front();
				for (int i = 0; i < mqm_pkg::LANES; i++) begin
					if (seen.mix[i] !== want.mix[i]) begin
						$display("%0t: %s expected %0d actual %0d", $time, lane_name[i],
							$signed(want.mix[i]), $signed(seen.mix[i]));
						mismatch_count++;
					end
				end
				if (seen.scaled !== want.scaled) begin
					$display("%0t: was_scaled expected %0b actual %0b", $time,
						want.scaled, seen.scaled);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_mixes();
		test_limit_extremes();
		test_random_mixes();
		finish_phase();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
